// ===== hdl/tsm_pkg.sv =====
// Shared constants and control/status types for the two-way sorted merge.
package tsm_pkg;

	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int VALUE_WIDTH_DEF = 32;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic one;
	} q_stat_t;

endpackage

// ===== hdl/tsm_if.sv =====
// Valid/ready channel interfaces for input items and merged results.
interface tsm_item_if #(
	parameter int VALUE_WIDTH = tsm_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          list_select;
	logic signed [VALUE_WIDTH-1:0] item_value;
	logic                          last_of_list;

	modport source (output valid, list_select, item_value, last_of_list, input ready);
	modport sink (input valid, list_select, item_value, last_of_list, output ready);
endinterface

interface tsm_result_if #(
	parameter int VALUE_WIDTH = tsm_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] out_value;
	logic                          out_source;
	logic                          last_of_merge;
	logic                          overflow;

	modport source (output valid, out_value, out_source, last_of_merge, overflow, input ready);
	modport sink (input valid, out_value, out_source, last_of_merge, overflow, output ready);
endinterface

// ===== hdl/two_way_sorted_merge.sv =====
// Two-way merge of ascending signed sequences held in two RAM-based queues.
// The first result is registered in ST_DECIDE, after the input transaction and the ST_READ state.
// An item passes ST_READ (head read of the queue RAMs), then ST_DECIDE with one
// compare-and-pop per cycle while the output register can load; new items wait for ST_IDLE.
// An overflow result is registered in the accept cycle.
// Reset clears queue pointers, counts, end flags and the output register.
module two_way_sorted_merge #(
	parameter int QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH_DEF,
	parameter int VALUE_WIDTH = tsm_pkg::VALUE_WIDTH_DEF
) (
	input logic             clk,
	input logic             arst_n,
	tsm_item_if.sink        items,
	tsm_result_if.source    results
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DECIDE
	} state_t;

	state_t                 state_q;
	logic                   fin_a_q;
	logic                   fin_b_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_source_q;
	logic                   out_last_q;
	logic                   out_ovf_q;

	tsm_pkg::q_ctrl_t       ctrl_a;
	tsm_pkg::q_ctrl_t       ctrl_b;
	tsm_pkg::q_stat_t       stat_a;
	tsm_pkg::q_stat_t       stat_b;
	logic [VALUE_WIDTH-1:0] head_a;
	logic [VALUE_WIDTH-1:0] head_b;

	logic can_load;
	logic accept;
	logic in_full;
	logic both;
	logic do_pop;
	logic take_b;
	logic is_last;
	logic emit;
	logic load_out;

	assign can_load = !out_valid_q || results.ready;
	assign items.ready = (state_q == ST_IDLE) && can_load;
	assign accept = items.valid && items.ready;
	assign in_full = items.list_select ? stat_b.full : stat_a.full;

	assign both = !stat_a.empty && !stat_b.empty;
	always_comb begin
		do_pop = 1'b1;
		take_b = 1'b0;
		if (both) begin
			take_b = !($signed(head_a) < $signed(head_b));
		end else if (stat_a.empty && fin_a_q && !stat_b.empty) begin
			take_b = 1'b1;
		end else if (stat_b.empty && fin_b_q && !stat_a.empty) begin
			take_b = 1'b0;
		end else begin
			do_pop = 1'b0;
		end
	end

	assign is_last = fin_a_q && fin_b_q &&
		(take_b ? (stat_b.one && stat_a.empty) : (stat_a.one && stat_b.empty));
	assign emit = (state_q == ST_DECIDE) && do_pop && can_load;
	assign load_out = (accept && in_full) || emit;

	assign ctrl_a.push = accept && !items.list_select && !in_full;
	assign ctrl_b.push = accept && items.list_select && !in_full;
	assign ctrl_a.pop  = emit && !take_b;
	assign ctrl_b.pop  = emit && take_b;

	tsm_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_queue_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_a),
		.wdata    (items.item_value),
		.head_data(head_a),
		.stat     (stat_a)
	);

	tsm_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_queue_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_b),
		.wdata    (items.item_value),
		.head_data(head_b),
		.stat     (stat_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fin_a_q      <= 1'b0;
			fin_b_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_source_q <= 1'b0;
			out_last_q   <= 1'b0;
			out_ovf_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_full) begin
							out_value_q  <= items.item_value;
							out_source_q <= items.list_select;
							out_last_q   <= 1'b0;
							out_ovf_q    <= 1'b1;
						end else begin
							if (items.last_of_list && !items.list_select) begin
								fin_a_q <= 1'b1;
							end
							if (items.last_of_list && items.list_select) begin
								fin_b_q <= 1'b1;
							end
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!do_pop) begin
						state_q <= ST_IDLE;
					end else if (can_load) begin
						out_value_q  <= take_b ? head_b : head_a;
						out_source_q <= take_b;
						out_last_q   <= is_last;
						out_ovf_q    <= 1'b0;
						if (is_last) begin
							fin_a_q <= 1'b0;
							fin_b_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid         = out_valid_q;
	assign results.out_value     = out_value_q;
	assign results.out_source    = out_source_q;
	assign results.last_of_merge = out_last_q;
	assign results.overflow      = out_ovf_q;

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_a.pop && ctrl_b.pop))
		else $error("both queues popped at once");
	a_flags_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && is_last) |=> (!fin_a_q && !fin_b_q && state_q == ST_IDLE))
		else $error("end flags not cleared after final transaction");
	a_read_then_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_full) |=> state_q == ST_READ ##1 state_q == ST_DECIDE)
		else $error("queued item not followed by head read");
	a_last_not_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ovf_q |-> !out_last_q)
		else $error("overflow transaction marked last");
endmodule

// ===== hdl/tsm_queue.sv =====
// Circular FIFO queue held in a synchronous RAM with a registered head read.
module tsm_queue #(
	parameter int QUEUE_DEPTH = tsm_pkg::QUEUE_DEPTH_DEF,
	parameter int VALUE_WIDTH = tsm_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tsm_pkg::q_ctrl_t       ctrl,
	input  logic [VALUE_WIDTH-1:0] wdata,
	output logic [VALUE_WIDTH-1:0] head_data,
	output tsm_pkg::q_stat_t       stat
);
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [VALUE_WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_q;
	logic [PTR_W-1:0]       head_q;
	logic [PTR_W-1:0]       head_d;
	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       tail_sum;
	logic [SUM_W-1:0]       tail_wrap;
	logic [PTR_W-1:0]       wr_addr;

	assign tail_sum  = SUM_W'(head_q) + SUM_W'(count_q);
	assign tail_wrap = tail_sum - SUM_W'(QUEUE_DEPTH);
	assign wr_addr   = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ? tail_wrap[PTR_W-1:0]
	                                                     : tail_sum[PTR_W-1:0];

	always_comb begin
		head_d = head_q;
		if (ctrl.pop) begin
			head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_addr] <= wdata;
		end
		rd_q <= mem[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_q + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);
		end
	end

	assign head_data  = rd_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.one   = (count_q == CNT_W'(1));

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !stat.full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !stat.empty)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");
endmodule
